@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the timer queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define DLTQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When pre holds, post must hold in the following cycle.
`define DLTQ_CHECK_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/dltq_pkg.sv @@
// Types, codes and constants of the delta list timer queue.
package dltq_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int ID_W   = 4;
  localparam int DL_W   = 32;
  localparam int PERT_W = 30;
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_START  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_EXPIRED  = 2'd1;
  localparam logic [1:0] KIND_TIMELEFT = 2'd2;
  localparam logic [1:0] KIND_TICK     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_START,
    ST_INS_MOD,
    ST_INS_PERT,
    ST_INS_WALK,
    ST_REM_WALK,
    ST_QRY_WALK,
    ST_TICK_HEAD,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_REM,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t        op;
    logic [ID_W-1:0] new_id;
    logic [DL_W-1:0] new_dl;
  } cell_ctl_t;

endpackage

@@ rtl/core/dltq_cell.sv @@
// One list position: timer id and delta, shifted with its neighbors.
module dltq_cell #(
  parameter int IDX_W = $clog2(dltq_pkg::NUM_TIMERS_DEF),
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  dltq_pkg::cell_ctl_t       ctl,
  input  logic [IDX_W-1:0]          pos,
  input  logic [dltq_pkg::ID_W-1:0] left_id,
  input  logic [dltq_pkg::DL_W-1:0] left_dl,
  input  logic [dltq_pkg::ID_W-1:0] right_id,
  input  logic [dltq_pkg::DL_W-1:0] right_dl,
  output logic [dltq_pkg::ID_W-1:0] cell_id,
  output logic [dltq_pkg::DL_W-1:0] cell_dl
);

  localparam logic [IDX_W:0] ME = (IDX_W+1)'(INDEX);

  logic [dltq_pkg::ID_W-1:0] id_next;
  logic [dltq_pkg::DL_W-1:0] dl_next;
  logic [IDX_W:0]            posx;
  logic [IDX_W:0]            posx1;

  assign posx  = {1'b0, pos};
  assign posx1 = posx + 1'b1;

  always_comb begin
    id_next = cell_id;
    dl_next = cell_dl;
    case (ctl.op)
      dltq_pkg::OP_INS: begin
        if (ME == posx) begin
          id_next = ctl.new_id;
          dl_next = ctl.new_dl;
        end else if (ME == posx1) begin
          // old occupant of the slot moves up, minus the new delta
          id_next = left_id;
          dl_next = left_dl - ctl.new_dl;
        end else if (ME > posx) begin
          id_next = left_id;
          dl_next = left_dl;
        end
      end
      dltq_pkg::OP_REM: begin
        if (ME == posx) begin
          id_next = right_id;
          dl_next = right_dl + cell_dl;
        end else if (ME > posx) begin
          id_next = right_id;
          dl_next = right_dl;
        end
      end
      dltq_pkg::OP_POP: begin
        id_next = right_id;
        dl_next = right_dl;
      end
      default: begin
        id_next = cell_id;
        dl_next = cell_dl;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cell_id <= id_next;
    cell_dl <= dl_next;
  end

endmodule

@@ rtl/core/dltq_mod.sv @@
// Restoring remainder unit, one dividend bit per cycle.
module dltq_mod (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [30:0] rem
);

  logic        active;
  logic [5:0]  cnt;
  logic [31:0] dvd;
  logic [30:0] dvs;
  logic [31:0] trial;

  assign trial = {rem, dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        cnt    <= 6'd32;
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (active) begin
      dvd <= {dvd[30:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        rem <= 31'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[30:0];
      end
    end
  end

endmodule

@@ rtl/core/delta_list_timer_queue.sv @@
// Delta list timer queue: sorted chain of timer cells with a command sequencer.
// Start/stop/update/query walk the list, one cell per cycle; an insert with nonzero
// perturbation first runs the remainder unit. A tick pops each expired head and
// re-inserts every re-armed timer.
// One command at a time; busy is high from accept until the last beat is issued.
// Results are one-cycle strobed beats. Reset (sync, high) empties the list at once.
module delta_list_timer_queue #(
  parameter int NUM_TIMERS = dltq_pkg::NUM_TIMERS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [3:0]  timer_id,
  input  logic [31:0] interval_ms,
  input  logic        repeat_req,
  input  logic [29:0] perturb_ms,
  input  logic [31:0] random_word,
  input  logic [31:0] elapsed_ms,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [3:0]  fired_or_named_id,
  output logic [31:0] remaining_ms,
  output logic        ok,
  output logic        last
);

  `include "assert_macros.svh"

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int ACC_W = 32 + CNT_W;

  dltq_pkg::state_t state, state_next;

  // latched command beat
  logic [2:0]  cmd_q;
  logic [3:0]  id_q;
  logic [31:0] ival_q;
  logic        rep_q;
  logic [29:0] pert_q;
  logic [31:0] rnd_q;
  logic [31:0] el_q;

  // per-timer settings
  logic [NUM_TIMERS-1:0] running;
  logic [NUM_TIMERS-1:0] repeat_f;
  logic [NUM_TIMERS-1:0] fired;
  logic [31:0]           st_ival [NUM_TIMERS];
  logic [29:0]           st_pert [NUM_TIMERS];

  logic [31:0]      accum;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pos;
  logic [ACC_W-1:0] acc;
  logic [3:0]       ins_id;
  logic [31:0]      ins_ival;
  logic             ok_q;
  logic [31:0]      rem_q;

  // cell chain
  dltq_pkg::cell_ctl_t ctl;
  logic [3:0]  cell_id [NUM_TIMERS];
  logic [31:0] cell_dl [NUM_TIMERS];

  // remainder unit
  logic        mod_go;
  logic        mod_done;
  logic [30:0] mod_rem;

  // output beat, next values
  logic        strobe_next;
  logic [1:0]  kind_next;
  logic [3:0]  fid_next;
  logic [31:0] rem_next;
  logic        ok_next;
  logic        last_next;

  // shared decode
  logic [IDX_W-1:0] id_ix, h_ix, ins_ix;
  logic [3:0]       head_id, cur_id;
  logic [31:0]      head_dl, cur_dl;
  logic             id_valid, cmd_valid, in_range, ins_go_on, id_hit, head_fire;
  logic [ACC_W-1:0] walk_sum;
  logic [ACC_W-1:0] qry_diff;
  logic [32:0]      accum_sum;
  logic [33:0]      pert_sum;
  logic [31:0]      pert_clamp;
  logic [31:0]      qry_val;

  // check terms
  logic             tick_end_now;
  logic             tick_beat;

  assign busy    = (state != dltq_pkg::ST_IDLE);
  assign id_ix   = IDX_W'(id_q);
  assign h_ix    = IDX_W'(head_id);
  assign ins_ix  = IDX_W'(ins_id);
  assign head_id = cell_id[0];
  assign head_dl = cell_dl[0];
  assign cur_id  = cell_id[pos];
  assign cur_dl  = cell_dl[pos];

  assign id_valid  = {28'd0, id_q} < 32'(NUM_TIMERS);
  assign cmd_valid = (cmd_q <= dltq_pkg::CMD_QUERY) && id_valid;
  assign in_range  = CNT_W'(pos) < count;
  assign walk_sum  = acc + ACC_W'(cur_dl);
  assign ins_go_on = in_range && (walk_sum < ACC_W'(ins_ival));
  assign id_hit    = (cur_id == id_q);
  assign head_fire = (count != '0) && !fired[h_ix] && (head_dl <= accum);
  assign accum_sum = {1'b0, accum} + {1'b0, el_q};

  // perturbed interval: ival + (rnd mod 2p) - p, clamped
  assign pert_sum = {2'b00, st_ival[ins_ix]} + {3'b000, mod_rem} - {4'b0000, st_pert[ins_ix]};
  assign pert_clamp = pert_sum[33] ? 32'd0 : (pert_sum[32] ? 32'hFFFF_FFFF : pert_sum[31:0]);

  // time left: walked sum minus the accumulator, floored at zero, saturated
  assign qry_diff = walk_sum - ACC_W'(accum);
  assign qry_val  = (ACC_W'(accum) > walk_sum) ? 32'd0 :
                    ((|qry_diff[ACC_W-1:32]) ? 32'hFFFF_FFFF : qry_diff[31:0]);

  assign tick_end_now = (state == dltq_pkg::ST_TICK_HEAD) && !head_fire;
  assign tick_beat    = strobe && last && (kind == dltq_pkg::KIND_TICK);

  // ---------------- cell chain ----------------
  for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_cell
    logic [3:0]  l_id, r_id;
    logic [31:0] l_dl, r_dl;
    if (k == 0) begin : g_first
      assign l_id = cell_id[k];
      assign l_dl = cell_dl[k];
    end else begin : g_mid_l
      assign l_id = cell_id[k-1];
      assign l_dl = cell_dl[k-1];
    end
    if (k == NUM_TIMERS - 1) begin : g_lastc
      assign r_id = cell_id[k];
      assign r_dl = cell_dl[k];
    end else begin : g_mid_r
      assign r_id = cell_id[k+1];
      assign r_dl = cell_dl[k+1];
    end
    dltq_cell #(.IDX_W(IDX_W), .INDEX(k)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos      (pos),
      .left_id  (l_id),
      .left_dl  (l_dl),
      .right_id (r_id),
      .right_dl (r_dl),
      .cell_id  (cell_id[k]),
      .cell_dl  (cell_dl[k])
    );
  end

  dltq_mod u_mod (
    .clk      (clk),
    .rst      (rst),
    .go       (mod_go),
    .dividend (rnd_q),
    .divisor  ({st_pert[ins_ix], 1'b0}),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (start) state_next = dltq_pkg::ST_DISPATCH;
      end
      dltq_pkg::ST_DISPATCH: begin
        if (cmd_q == dltq_pkg::CMD_TICK) begin
          state_next = dltq_pkg::ST_TICK_HEAD;
        end else if (!cmd_valid) begin
          state_next = dltq_pkg::ST_FINISH;
        end else if (cmd_q == dltq_pkg::CMD_START) begin
          state_next = running[id_ix] ? dltq_pkg::ST_FINISH : dltq_pkg::ST_INS_START;
        end else if (cmd_q == dltq_pkg::CMD_QUERY) begin
          state_next = running[id_ix] ? dltq_pkg::ST_QRY_WALK : dltq_pkg::ST_FINISH;
        end else begin
          state_next = running[id_ix] ? dltq_pkg::ST_REM_WALK : dltq_pkg::ST_FINISH;
        end
      end
      dltq_pkg::ST_INS_START: begin
        state_next = (st_pert[ins_ix] == '0) ? dltq_pkg::ST_INS_WALK : dltq_pkg::ST_INS_MOD;
      end
      dltq_pkg::ST_INS_MOD: begin
        if (mod_done) state_next = dltq_pkg::ST_INS_PERT;
      end
      dltq_pkg::ST_INS_PERT: state_next = dltq_pkg::ST_INS_WALK;
      dltq_pkg::ST_INS_WALK: begin
        if (!ins_go_on) begin
          state_next = (cmd_q == dltq_pkg::CMD_TICK) ? dltq_pkg::ST_TICK_HEAD
                                                     : dltq_pkg::ST_FINISH;
        end
      end
      dltq_pkg::ST_REM_WALK: begin
        if (id_hit) begin
          state_next = (cmd_q == dltq_pkg::CMD_STOP) ? dltq_pkg::ST_FINISH
                                                     : dltq_pkg::ST_INS_START;
        end
      end
      dltq_pkg::ST_QRY_WALK: begin
        if (id_hit) state_next = dltq_pkg::ST_FINISH;
      end
      dltq_pkg::ST_TICK_HEAD: begin
        if (!head_fire) begin
          state_next = dltq_pkg::ST_IDLE;
        end else if (repeat_f[h_ix]) begin
          state_next = dltq_pkg::ST_INS_START;
        end
      end
      dltq_pkg::ST_FINISH: state_next = dltq_pkg::ST_IDLE;
      default: state_next = dltq_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs: cell control, remainder start, result beat ----------------
  always_comb begin
    ctl         = '{op: dltq_pkg::OP_HOLD, new_id: ins_id, new_dl: ins_ival - acc[31:0]};
    mod_go      = 1'b0;
    strobe_next = 1'b0;
    kind_next   = dltq_pkg::KIND_ACK;
    fid_next    = id_q;
    rem_next    = 32'd0;
    ok_next     = 1'b0;
    last_next   = 1'b0;
    case (state)
      dltq_pkg::ST_INS_START: begin
        mod_go = (st_pert[ins_ix] != '0);
      end
      dltq_pkg::ST_INS_WALK: begin
        if (!ins_go_on) ctl.op = dltq_pkg::OP_INS;
      end
      dltq_pkg::ST_REM_WALK: begin
        if (id_hit) ctl.op = dltq_pkg::OP_REM;
      end
      dltq_pkg::ST_TICK_HEAD: begin
        strobe_next = 1'b1;
        if (head_fire) begin
          ctl.op    = dltq_pkg::OP_POP;
          kind_next = dltq_pkg::KIND_EXPIRED;
          fid_next  = head_id;
          ok_next   = repeat_f[h_ix];
        end else begin
          kind_next = dltq_pkg::KIND_TICK;
          fid_next  = 4'd0;
          last_next = 1'b1;
        end
      end
      dltq_pkg::ST_FINISH: begin
        strobe_next = 1'b1;
        kind_next   = (cmd_q == dltq_pkg::CMD_QUERY && id_valid) ? dltq_pkg::KIND_TIMELEFT
                                                                 : dltq_pkg::KIND_ACK;
        rem_next    = rem_q;
        ok_next     = ok_q;
        last_next   = 1'b1;
      end
      default: begin
        ctl.op = dltq_pkg::OP_HOLD;
      end
    endcase
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= dltq_pkg::ST_IDLE;
      strobe   <= 1'b0;
      running  <= '0;
      repeat_f <= '0;
      fired    <= '0;
      st_ival  <= '{default: '0};
      st_pert  <= '{default: '0};
      accum    <= '0;
      count    <= '0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
      case (state)
        dltq_pkg::ST_DISPATCH: begin
          if (cmd_q == dltq_pkg::CMD_TICK) begin
            accum <= accum_sum[32] ? 32'hFFFF_FFFF : accum_sum[31:0];
            fired <= '0;
          end else if (cmd_valid) begin
            if (cmd_q == dltq_pkg::CMD_START && !running[id_ix]) begin
              running[id_ix]  <= 1'b1;
              repeat_f[id_ix] <= rep_q;
              st_ival[id_ix]  <= ival_q;
              st_pert[id_ix]  <= pert_q;
            end
            if (cmd_q == dltq_pkg::CMD_STOP) running[id_ix] <= 1'b0;
            if (cmd_q == dltq_pkg::CMD_UPDATE) begin
              repeat_f[id_ix] <= rep_q;
              st_ival[id_ix]  <= ival_q;
              st_pert[id_ix]  <= pert_q;
            end
          end
        end
        dltq_pkg::ST_INS_START: begin
          // first entry of an empty list restarts the time base
          if (count == '0) accum <= '0;
        end
        dltq_pkg::ST_INS_WALK: begin
          if (!ins_go_on) count <= count + 1'b1;
        end
        dltq_pkg::ST_REM_WALK: begin
          if (id_hit) count <= count - 1'b1;
        end
        dltq_pkg::ST_TICK_HEAD: begin
          if (head_fire) begin
            accum       <= accum - head_dl;
            count       <= count - 1'b1;
            fired[h_ix] <= 1'b1;
            if (!repeat_f[h_ix]) running[h_ix] <= 1'b0;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    kind              <= kind_next;
    fired_or_named_id <= fid_next;
    remaining_ms      <= rem_next;
    ok                <= ok_next;
    last              <= last_next;
    case (state)
      dltq_pkg::ST_IDLE: begin
        if (start) begin
          cmd_q  <= command;
          id_q   <= timer_id;
          ival_q <= interval_ms;
          rep_q  <= repeat_req;
          pert_q <= perturb_ms;
          rnd_q  <= random_word;
          el_q   <= elapsed_ms;
        end
      end
      dltq_pkg::ST_DISPATCH: begin
        rem_q  <= 32'd0;
        pos    <= '0;
        acc    <= '0;
        ins_id <= id_q;
        if (!cmd_valid) begin
          ok_q <= 1'b0;
        end else if (cmd_q == dltq_pkg::CMD_START) begin
          ok_q <= 1'b1;
        end else begin
          ok_q <= running[id_ix];
        end
      end
      dltq_pkg::ST_INS_START: begin
        pos <= '0;
        acc <= '0;
        if (st_pert[ins_ix] == '0) ins_ival <= st_ival[ins_ix];
      end
      dltq_pkg::ST_INS_PERT: begin
        ins_ival <= pert_clamp;
      end
      dltq_pkg::ST_INS_WALK: begin
        if (ins_go_on) begin
          acc <= walk_sum;
          pos <= pos + 1'b1;
        end
      end
      dltq_pkg::ST_REM_WALK: begin
        if (!id_hit) pos <= pos + 1'b1;
      end
      dltq_pkg::ST_QRY_WALK: begin
        if (id_hit) begin
          rem_q <= qry_val;
        end else begin
          acc <= walk_sum;
          pos <= pos + 1'b1;
        end
      end
      dltq_pkg::ST_TICK_HEAD: begin
        if (head_fire) ins_id <= head_id;
      end
      default: begin
        pos <= pos;
      end
    endcase
  end

  // ---------------- assertions ----------------
  `DLTQ_CHECK(a_count_max, count <= CNT_W'(NUM_TIMERS), "queue count above capacity")
  `DLTQ_CHECK(a_idle_count, busy || (int'(count) == $countones(running)), "queue vs running")
  `DLTQ_CHECK_NEXT(a_finish_beat, state == dltq_pkg::ST_FINISH, strobe && last, "no final beat")
  `DLTQ_CHECK_NEXT(a_tick_end, tick_end_now, tick_beat, "missing tick done beat")

endmodule

@@ sim/delta_list_timer_queue_chk.sv @@
// Result checker for the delta list timer queue: predicts and compares every beat.
module delta_list_timer_queue_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  command,
  input  logic [3:0]  timer_id,
  input  logic [31:0] interval_ms,
  input  logic        repeat_req,
  input  logic [29:0] perturb_ms,
  input  logic [31:0] random_word,
  input  logic [31:0] elapsed_ms,
  input  logic        strobe,
  input  logic [1:0]  kind,
  input  logic [3:0]  fired_or_named_id,
  input  logic [31:0] remaining_ms,
  input  logic        ok,
  input  logic        last,
  output int          errors,
  output int          pending,
  output int          fired_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [31:0] rem;
    logic        ok;
    logic        last;
  } beat_t;

  beat_t due_beats[$];

  logic [3:0]  list_id[NT];
  logic [31:0] list_dl[NT];
  int          list_len;
  logic        run_f[NT], rep_f[NT];
  logic [31:0] ival_f[NT];
  logic [29:0] pert_f[NT];
  logic [31:0] accum;

  function automatic logic [31:0] jitter(logic [31:0] iv, logic [29:0] p, logic [31:0] r);
    longint v;
    if (p == 0) return iv;
    v = longint'(iv) + longint'(r % ({2'b0, p} * 2)) - longint'(p);
    if (v < 0) return 0;
    if (v > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return v[31:0];
  endfunction

  task automatic list_insert(logic [3:0] id, logic [31:0] r);
    logic [31:0] iv;
    longint acc;
    int pos;
    logic [31:0] nd;
    iv = jitter(ival_f[id], pert_f[id], r);
    acc = 0;
    pos = 0;
    if (list_len >= NT) return;
    if (list_len == 0) accum = 0;
    while (pos < list_len && acc + list_dl[pos] < iv) begin
      acc += list_dl[pos];
      pos++;
    end
    nd = 32'(longint'(iv) - acc);
    if (pos < list_len) list_dl[pos] -= nd;
    for (int j = list_len; j > pos; j--) begin
      list_id[j] = list_id[j-1];
      list_dl[j] = list_dl[j-1];
    end
    list_id[pos] = id;
    list_dl[pos] = nd;
    list_len++;
  endtask

  task automatic list_remove(logic [3:0] id);
    for (int p = 0; p < list_len; p++) begin
      if (list_id[p] == id) begin
        if (p + 1 < list_len) list_dl[p+1] += list_dl[p];
        for (int j = p; j + 1 < list_len; j++) begin
          list_id[j] = list_id[j+1];
          list_dl[j] = list_dl[j+1];
        end
        list_len--;
        return;
      end
    end
  endtask

  function automatic logic [31:0] left_of(logic [3:0] id);
    longint acc;
    acc = 0;
    if (!run_f[id]) return 0;
    for (int p = 0; p < list_len; p++) begin
      acc += list_dl[p];
      if (list_id[p] == id) break;
    end
    if (longint'(accum) > acc) return 0;
    acc -= accum;
    return acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0];
  endfunction

  task automatic predict_cmd();
    logic fired[NT];
    longint s;
    logic [3:0] h;
    logic was;
    if (command == dltq_pkg::CMD_TICK) begin
      s = longint'(accum) + elapsed_ms;
      accum = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
      foreach (fired[i]) fired[i] = 0;
      while (list_len > 0) begin
        h = list_id[0];
        if (fired[h] || list_dl[0] > accum) break;
        accum -= list_dl[0];
        for (int j = 0; j + 1 < list_len; j++) begin
          list_id[j] = list_id[j+1];
          list_dl[j] = list_dl[j+1];
        end
        list_len--;
        fired[h] = 1;
        if (rep_f[h]) list_insert(h, random_word);
        else run_f[h] = 0;
        due_beats.push_back('{dltq_pkg::KIND_EXPIRED, h, 32'd0, rep_f[h], 1'b0});
      end
      due_beats.push_back('{dltq_pkg::KIND_TICK, 4'd0, 32'd0, 1'b0, 1'b1});
    end else if (command > dltq_pkg::CMD_QUERY) begin
      due_beats.push_back('{dltq_pkg::KIND_ACK, timer_id, 32'd0, 1'b0, 1'b1});
    end else if (command == dltq_pkg::CMD_START) begin
      if (!run_f[timer_id]) begin
        run_f[timer_id] = 1;
        rep_f[timer_id] = repeat_req;
        ival_f[timer_id] = interval_ms;
        pert_f[timer_id] = perturb_ms;
        list_insert(timer_id, random_word);
      end
      due_beats.push_back('{dltq_pkg::KIND_ACK, timer_id, 32'd0, 1'b1, 1'b1});
    end else if (command == dltq_pkg::CMD_STOP) begin
      was = run_f[timer_id];
      if (was) begin
        list_remove(timer_id);
        run_f[timer_id] = 0;
      end
      due_beats.push_back('{dltq_pkg::KIND_ACK, timer_id, 32'd0, was, 1'b1});
    end else if (command == dltq_pkg::CMD_UPDATE) begin
      ival_f[timer_id] = interval_ms;
      rep_f[timer_id] = repeat_req;
      pert_f[timer_id] = perturb_ms;
      if (run_f[timer_id]) begin
        list_remove(timer_id);
        list_insert(timer_id, random_word);
      end
      due_beats.push_back('{dltq_pkg::KIND_ACK, timer_id, 32'd0, run_f[timer_id], 1'b1});
    end else begin
      due_beats.push_back('{dltq_pkg::KIND_TIMELEFT, timer_id, left_of(timer_id),
                            run_f[timer_id], 1'b1});
    end
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (rst) begin
      due_beats.delete();
      list_len = 0;
      accum = 0;
      foreach (run_f[i]) begin
        run_f[i] = 0; rep_f[i] = 0; ival_f[i] = 0; pert_f[i] = 0;
      end
      errors = 0;
      fired_seen = 0;
    end else begin
      if (strobe) begin
        got = '{kind, fired_or_named_id, remaining_ms, ok, last};
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          errors++;
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected kind %0d id %0d rem %0d ok %0d last %0d",
                     $time, want.kind, want.id, want.rem, want.ok, want.last);
            $display("%0t:          actual   kind %0d id %0d rem %0d ok %0d last %0d",
                     $time, got.kind, got.id, got.rem, got.ok, got.last);
            errors++;
          end
          if (got.kind == dltq_pkg::KIND_EXPIRED) fired_seen++;
        end
      end
      if (start && !busy) predict_cmd();
    end
    pending = due_beats.size();
  end
endmodule

@@ sim/delta_list_timer_queue_tb.sv @@
// Testbench top for the delta list timer queue: stimulus, watchdog and verdict.
module delta_list_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst, start, busy;
  logic [2:0]  command;
  logic [3:0]  timer_id;
  logic [31:0] interval_ms, random_word, elapsed_ms;
  logic        repeat_req;
  logic [29:0] perturb_ms;
  logic        strobe, ok, last;
  logic [1:0]  kind;
  logic [3:0]  fired_or_named_id;
  logic [31:0] remaining_ms;
  int          errors, pending, fired_seen;
  int          n_cmds;
  int          idle_cnt;
  bit          quiet_tail;

  localparam int WATCHDOG = 20000;

  delta_list_timer_queue uut (.*);
  delta_list_timer_queue_chk chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if (rst || strobe || (start && !busy)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  // one command beat; start stays up until the block takes it, and drops only for a gap
  task automatic issue(logic [2:0] c, logic [3:0] id, logic [31:0] iv, logic rp,
                       logic [29:0] pt, logic [31:0] rw, logic [31:0] el);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    command <= c; timer_id <= id; interval_ms <= iv; repeat_req <= rp;
    perturb_ms <= pt; random_word <= rw; elapsed_ms <= el;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_cmds++;
  endtask

  // intervals mostly small so ticks actually expire things
  function automatic logic [31:0] pick_ival();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      2: return 0;
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic logic [29:0] pick_pert();
    case ($urandom_range(0, 7))
      0: return 30'h3FFF_FFFF;
      1: return 30'($urandom);
      2, 3: return 30'($urandom_range(1, 60));
      default: return 0;
    endcase
  endfunction

  function automatic logic [31:0] pick_el();
    case ($urandom_range(0, 9))
      0: return 32'hFFFF_FFFF;
      1: return $urandom;
      2: return 0;
      default: return $urandom_range(0, 200);
    endcase
  endfunction

  initial begin
    logic [2:0] c;
    int r;
    n_cmds = 0;
    quiet_tail = 0;
    start = 0; command = 0; timer_id = 0; interval_ms = 0; repeat_req = 0;
    perturb_ms = 0; random_word = 0; elapsed_ms = 0;
    rst = 1;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: field extremes, each command, the named corner cases
    issue(dltq_pkg::CMD_QUERY, 4'd3, 0, 0, 0, 0, 0);           // query stopped
    issue(dltq_pkg::CMD_UPDATE, 4'd5, 32'd50, 1, 0, 0, 0);     // update stopped
    issue(dltq_pkg::CMD_START, 4'd0, 32'd10, 1, 0, 0, 0);      // insert into empty
    issue(dltq_pkg::CMD_START, 4'd0, 32'd99, 0, 0, 0, 0);      // start while running
    issue(dltq_pkg::CMD_START, 4'd15, 32'hFFFF_FFFF, 0, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 0);
    issue(dltq_pkg::CMD_START, 4'd1, 32'd5, 0, 30'd20, 32'd3, 0); // perturb clamps at zero
    issue(dltq_pkg::CMD_START, 4'd2, 32'd10, 1, 0, 0, 0);
    issue(dltq_pkg::CMD_QUERY, 4'd15, 0, 0, 0, 0, 0);
    issue(dltq_pkg::CMD_TICK, 4'd0, 0, 0, 0, 32'd7, 32'd30);   // refire in one tick
    issue(dltq_pkg::CMD_QUERY, 4'd0, 0, 0, 0, 0, 0);
    issue(dltq_pkg::CMD_UPDATE, 4'd2, 32'd40, 0, 30'd5, 32'd9, 0); // update running
    issue(dltq_pkg::CMD_STOP, 4'd2, 0, 0, 0, 0, 0);
    issue(dltq_pkg::CMD_STOP, 4'd2, 0, 0, 0, 0, 0);            // stop not running
    issue(3'd5, 4'd4, 0, 0, 0, 0, 0);                          // unknown commands
    issue(3'd7, 4'd15, 32'hFFFF_FFFF, 1, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(dltq_pkg::CMD_TICK, 4'd9, 0, 0, 0, 0, 32'hFFFF_FFFF); // accumulator saturates
    issue(dltq_pkg::CMD_TICK, 4'd0, 0, 0, 0, 0, 32'hFFFF_FFFF);
    issue(dltq_pkg::CMD_QUERY, 4'd15, 0, 0, 0, 0, 0);
    issue(dltq_pkg::CMD_START, 4'd3, 32'd0, 1, 0, 0, 0);       // zero-interval repeat
    issue(dltq_pkg::CMD_TICK, 4'd0, 0, 0, 0, 0, 0);

    // random: mostly starts and ticks over a busy list
    for (int i = 0; i < 270; i++) begin
      if (i > 230) quiet_tail = 1;
      r = $urandom_range(0, 99);
      if (r < 35) c = dltq_pkg::CMD_START;
      else if (r < 50) c = dltq_pkg::CMD_STOP;
      else if (r < 62) c = dltq_pkg::CMD_UPDATE;
      else if (r < 85) c = dltq_pkg::CMD_TICK;
      else if (r < 97) c = dltq_pkg::CMD_QUERY;
      else c = 3'($urandom_range(5, 7));
      issue(c, 4'($urandom), pick_ival(), 1'($urandom), pick_pert(), $urandom,
            pick_el());
    end
    start <= 0;

    r = 0;
    while (pending != 0 && r < WATCHDOG) begin
      @(posedge clk);
      r++;
    end
    repeat (100) @(posedge clk);
    $display("Ran %0d commands, %0d timer expiries checked.", n_cmds, fired_seen);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
